/* hw/rtl/rmc_pkg.sv */
// Package for the remote motion command controller.
// Holds the item, result and register types, the command codes and the angle conversions.
// No dependencies.
package rmc_pkg;

    // Input item kinds
    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_LEFT  = 2'd1,
        KIND_RIGHT = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_IR_LIMIT    = 2'd0,
        REG_RANGE_LIMIT = 2'd1,
        REG_PAN_BAND    = 2'd2,
        REG_TILT_BAND   = 2'd3
    } reg_index_t;

    // Modes
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_HARD  = 2'd1;
    localparam logic [1:0] MODE_SOFT  = 2'd2;
    localparam logic [1:0] MODE_SERVO = 2'd3;

    // Command bytes and byte ranges
    localparam logic [7:0] CMD_FORWARD    = 8'd8;
    localparam logic [7:0] CMD_BACK       = 8'd9;
    localparam logic [7:0] CMD_STOP       = 8'd5;
    localparam logic [7:0] CMD_RIGHT_LO   = 8'd12;
    localparam logic [7:0] CMD_LEFT_LO    = 8'd55;
    localparam logic [7:0] CMD_TILT_LO    = 8'd90;
    localparam logic [7:0] RIGHT_OFFSET   = 8'd10;
    localparam logic [7:0] LEFT_OFFSET    = 8'd55;
    localparam logic [7:0] TILT_OFFSET    = 8'd90;

    // Motor direction patterns
    localparam logic [3:0] DRIVE_STOP       = 4'h0;
    localparam logic [3:0] DRIVE_FORWARD    = 4'h6;
    localparam logic [3:0] DRIVE_BACK       = 4'h9;
    localparam logic [3:0] DRIVE_HARD_LEFT  = 4'h5;
    localparam logic [3:0] DRIVE_HARD_RIGHT = 4'hA;
    localparam logic [3:0] DRIVE_SOFT_LEFT  = 4'h4;
    localparam logic [3:0] DRIVE_SOFT_RIGHT = 4'h2;

    // Register reset values
    localparam logic [7:0] IR_LIMIT_RST    = 8'd220;
    localparam logic [7:0] RANGE_LIMIT_RST = 8'd130;
    localparam logic [7:0] PAN_BAND_RST    = 8'd7;
    localparam logic [7:0] TILT_BAND_RST   = 8'd2;
    localparam logic [7:0] SERVO_BASE      = 8'd35;

    typedef struct packed {
        logic [7:0] ir_limit;
        logic [7:0] range_limit;
        logic [7:0] pan_band;
        logic [7:0] tilt_band;
    } cfg_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] command_byte;
        logic [7:0] ir_reading;
        logic [7:0] range_reading;
    } item_t;

    typedef struct packed {
        logic       turn_active;
        logic       obstacle_seen;
        logic [7:0] echo_byte;
        logic [1:0] current_mode;
        logic [7:0] tilt_compare;
        logic [7:0] pan_compare;
        logic [3:0] motor_drive;
    } result_t;

    // floor(a*40/153): reciprocal 857/2^17, exact for turn angles up to 200
    function automatic logic [5:0] count_for_angle(input logic [7:0] a);
        logic [13:0] n;
        logic [23:0] p;
        begin
            n = 14'(a) * 14'd40;
            p = 24'(n) * 24'd857;
            return p[22:17];
        end
    endfunction

    // floor(a*50/93)+35: reciprocal 2819/2^18, exact for a*50 up to 12750
    function automatic logic [7:0] compare_for_angle(input logic [7:0] a);
        logic [13:0] n;
        logic [25:0] p;
        begin
            n = 14'(a) * 14'd50;
            p = 26'(n) * 26'd2819;
            return p[25:18] + SERVO_BASE;
        end
    endfunction

    // |last - now| > band
    function automatic logic past_deadband(input logic [7:0] last, input logic [7:0] now,
                                           input logic [7:0] band);
        logic [7:0] d;
        begin
            d = (last >= now) ? (last - now) : (now - last);
            return d > band;
        end
    endfunction

endpackage

/* hw/rtl/rmc_cfg_regs.sv */
// Configuration register file: obstacle limits and servo deadbands.
// Depends on rmc_pkg.
module rmc_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [1:0]    wr_index,
    input  logic [7:0]    wr_data,
    output rmc_pkg::cfg_t cfg
);
    import rmc_pkg::*;

    cfg_t cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ir_limit    <= IR_LIMIT_RST;
            cfg_reg.range_limit <= RANGE_LIMIT_RST;
            cfg_reg.pan_band    <= PAN_BAND_RST;
            cfg_reg.tilt_band   <= TILT_BAND_RST;
        end
        else if (wr_en)
        begin
            case (reg_index_t'(wr_index))
                REG_IR_LIMIT:    cfg_reg.ir_limit    <= wr_data;
                REG_RANGE_LIMIT: cfg_reg.range_limit <= wr_data;
                REG_PAN_BAND:    cfg_reg.pan_band    <= wr_data;
                REG_TILT_BAND:   cfg_reg.tilt_band   <= wr_data;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/rmc_engine.sv */
// Controller state and its combinational update for one item.
// Depends on rmc_pkg. Result shows the state as it is after the item.
module rmc_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  rmc_pkg::item_t   item,
    input  rmc_pkg::cfg_t    cfg,
    output rmc_pkg::result_t result
);
    import rmc_pkg::*;

    logic [1:0] mode_reg,        mode_next;
    logic [3:0] drive_reg,       drive_next;
    logic       turning_reg,     turning_next;
    logic       watch_right_reg, watch_right_next;
    logic [5:0] target_reg,      target_next;
    logic [7:0] left_reg,        left_next;
    logic [7:0] right_reg,       right_next;
    logic [7:0] last_pan_reg,    last_pan_next;
    logic [7:0] last_tilt_reg,   last_tilt_next;
    logic [7:0] pan_reg,         pan_next;
    logic [7:0] tilt_reg,        tilt_next;
    logic       obstacle_reg,    obstacle_next;

    logic [7:0] b;
    logic [7:0] right_angle;
    logic [7:0] left_angle;
    logic [7:0] tilt_angle;
    logic       obst;
    logic       watched_pulse;
    logic [7:0] watched_count;

    assign b           = item.command_byte;
    assign right_angle = b - RIGHT_OFFSET;
    assign left_angle  = b - LEFT_OFFSET;
    assign tilt_angle  = b - TILT_OFFSET;
    assign obst        = (item.ir_reading < cfg.ir_limit) ||
                         (item.range_reading > cfg.range_limit);

    // Next state
    always_comb
    begin
        mode_next        = mode_reg;
        drive_next       = drive_reg;
        turning_next     = turning_reg;
        watch_right_next = watch_right_reg;
        target_next      = target_reg;
        left_next        = left_reg;
        right_next       = right_reg;
        last_pan_next    = last_pan_reg;
        last_tilt_next   = last_tilt_reg;
        pan_next         = pan_reg;
        tilt_next        = tilt_reg;
        obstacle_next    = obstacle_reg;
        watched_pulse    = 1'b0;
        watched_count    = left_reg;

        case (item.kind)
            KIND_BYTE:
            begin
                obstacle_next = obst;
                if (obst)
                    drive_next = DRIVE_STOP;

                // Decode, first match wins
                if (b inside {[8'd1:8'd3]})
                    mode_next = b[1:0];
                else if (mode_reg == MODE_HARD && b == CMD_FORWARD)
                begin
                    if (!obst)
                        drive_next = DRIVE_FORWARD;
                end
                else if (mode_reg == MODE_HARD && b == CMD_BACK)
                    drive_next = DRIVE_BACK;
                else if (mode_reg == MODE_HARD && b == CMD_STOP)
                    drive_next = DRIVE_STOP;
                else if ((mode_reg == MODE_HARD || mode_reg == MODE_SOFT) &&
                         b >= CMD_RIGHT_LO)
                begin
                    // Start a counted turn
                    left_next    = '0;
                    right_next   = '0;
                    turning_next = 1'b1;
                    if (b < CMD_LEFT_LO)
                    begin
                        target_next      = count_for_angle(right_angle);
                        watch_right_next = 1'b0;
                        drive_next       = (mode_reg == MODE_HARD) ? DRIVE_HARD_RIGHT
                                                                   : DRIVE_SOFT_RIGHT;
                    end
                    else
                    begin
                        target_next      = count_for_angle(left_angle);
                        watch_right_next = (mode_reg == MODE_SOFT);
                        drive_next       = (mode_reg == MODE_HARD) ? DRIVE_HARD_LEFT
                                                                   : DRIVE_SOFT_LEFT;
                    end
                end
                else if (mode_reg == MODE_SERVO && b >= CMD_TILT_LO)
                begin
                    if (past_deadband(last_tilt_reg, tilt_angle, cfg.tilt_band))
                    begin
                        tilt_next      = compare_for_angle(tilt_angle);
                        last_tilt_next = tilt_angle;
                    end
                end
                else if (mode_reg == MODE_SERVO)
                begin
                    if (past_deadband(last_pan_reg, b, cfg.pan_band))
                    begin
                        pan_next      = compare_for_angle(b);
                        last_pan_next = b;
                    end
                end
            end
            KIND_LEFT:
            begin
                if (left_reg != 8'hFF)
                    left_next = left_reg + 8'd1;
                watched_pulse = turning_reg && !watch_right_reg;
                watched_count = left_next;
            end
            KIND_RIGHT:
            begin
                if (right_reg != 8'hFF)
                    right_next = right_reg + 8'd1;
                watched_pulse = turning_reg && watch_right_reg;
                watched_count = right_next;
            end
            default:
            begin
                watched_pulse = 1'b0;
            end
        endcase

        // Turn ends once the watched wheel passes the target
        if (watched_pulse && watched_count > {2'b00, target_reg})
        begin
            drive_next   = DRIVE_STOP;
            turning_next = 1'b0;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_NONE;
            drive_reg       <= DRIVE_STOP;
            turning_reg     <= 1'b0;
            watch_right_reg <= 1'b0;
            target_reg      <= '0;
            left_reg        <= '0;
            right_reg       <= '0;
            last_pan_reg    <= '0;
            last_tilt_reg   <= '0;
            pan_reg         <= SERVO_BASE;
            tilt_reg        <= SERVO_BASE;
            obstacle_reg    <= 1'b0;
        end
        else if (step)
        begin
            mode_reg        <= mode_next;
            drive_reg       <= drive_next;
            turning_reg     <= turning_next;
            watch_right_reg <= watch_right_next;
            target_reg      <= target_next;
            left_reg        <= left_next;
            right_reg       <= right_next;
            last_pan_reg    <= last_pan_next;
            last_tilt_reg   <= last_tilt_next;
            pan_reg         <= pan_next;
            tilt_reg        <= tilt_next;
            obstacle_reg    <= obstacle_next;
        end
    end

    // Result from the updated state
    assign result.motor_drive   = drive_next;
    assign result.pan_compare   = pan_next;
    assign result.tilt_compare  = tilt_next;
    assign result.current_mode  = mode_next;
    assign result.echo_byte     = (item.kind == KIND_BYTE) ? b : 8'd0;
    assign result.obstacle_seen = obstacle_next;
    assign result.turn_active   = turning_next;

endmodule

/* hw/rtl/remote_motion_command_controller.sv */
// Top level of the remote motion command controller: stream ports, input and result registers.
// Depends on rmc_pkg, rmc_cfg_regs and rmc_engine.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready  | tdata: command, ir, range; tuser: kind
//  m_axis   | out       | m_axis_tvalid/tready  | tdata: one result item per input item
//  cfg      | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One item per cycle sustained while m_axis takes the results; after the input transaction the
// item passes the input register, then the state update into the result register.
// The state update runs when the input register holds an item and the result register is
// empty or being taken in the same cycle; a stalled m_axis holds both registers once full.
// rst_n resets the state, the valid flags and the configuration registers to their reset values.
// cfg_ready is always high.
module remote_motion_command_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // command_byte[7:0], ir_reading[15:8], range_reading[23:16]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // motor_drive[3:0], pan_compare[11:4], tilt_compare[19:12],
                                        // current_mode[21:20], echo_byte[29:22],
                                        // obstacle_seen[30], turn_active[31]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import rmc_pkg::*;

    logic    in_valid_reg;
    item_t   in_reg;
    logic    out_valid_reg;
    result_t out_reg;
    logic    step;
    cfg_t    cfg;
    result_t result;

    assign cfg_ready     = 1'b1;
    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    rmc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    rmc_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_reg.kind          <= kind_t'(s_axis_tuser);
            in_reg.command_byte  <= s_axis_tdata[7:0];
            in_reg.ir_reading    <= s_axis_tdata[15:8];
            in_reg.range_reading <= s_axis_tdata[23:16];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

endmodule
